// ----- rtl/dvrs_pkg.sv -----
`default_nettype none
package dvrs_pkg;

	// operation codes of an input beat
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SYNC   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_VLEN     = 2'd1;
	localparam logic [1:0] REG_TOL      = 2'd2;

	typedef enum logic [2:0] {
		STAT_STORED    = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_WRONG_LEN = 3'd2,
		STAT_READ      = 3'd3,
		STAT_SYNC_DONE = 3'd4
	} dvrs_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM_RD,
		ST_SUM_CHK,
		ST_EL_RD,
		ST_EL_CHK,
		ST_COPY,
		ST_COPY_END,
		ST_RD_RES
	} dvrs_state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] element_value;
		logic               last;
		logic [5:0]         read_slot;
		logic [5:0]         read_element;
	} dvrs_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         slot;
		logic [6:0]         count;
		logic [5:0]         write_position;
		logic [5:0]         sync_start;
		logic               wrapped;
		logic               full_res;
		logic signed [31:0] read_value;
	} dvrs_out_t;

endpackage
`default_nettype wire

// ----- rtl/dedup_vector_ring_store_top.sv -----
`default_nettype none
// Ring store of Q16.16 vectors that refuses duplicates.
// Input channel (item_valid/item_ready, payload item): one beat per element
// insert, sync reset or element read. Output channel (result_valid/
// result_ready, payload result): one beat for a last element, a sync reset
// or a read; a non-last element and operation 3 give none.
// A sync reset or a wrong-length last element gives its result in the cycle
// after acceptance; a read goes through ST_RD_RES, then the result register.
// A valid last element walks the stored slots, checking each slot's sum and,
// on a match, its elements; a mismatch moves on, and with no match the vector
// is copied through ST_COPY and ST_COPY_END. The scan/copy sequencer sets the
// rate; streaming elements go one a cycle while the result register is free.
// Configuration port: cfg_we, cfg_index, cfg_data; write only when idle.
// Reset clears the pointers, flags and counters; the store contents are
// undefined until written and need no clearing pass.
// A stalled receiver holds the result register; a new beat is taken only
// once the result register is empty or being drained.
module dedup_vector_ring_store_top #(
	parameter int SLOTS   = 64,
	parameter int MAX_DIM = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [30:0]      cfg_data,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire dvrs_pkg::dvrs_in_t  item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output dvrs_pkg::dvrs_out_t   result
);
	import dvrs_pkg::*;

	localparam int SW    = $clog2(SLOTS);
	localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW    = (SLOTS * MAX_DIM > 1) ? $clog2(SLOTS * MAX_DIM) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int ICW   = $clog2(MAX_DIM + 2);
	localparam int SUM_W = 32 + $clog2(MAX_DIM);

	// configuration
	logic [6:0]  cap_q, vlen_q;
	logic [30:0] tol_q;

	// control state
	dvrs_state_t     state_q, state_d;
	logic [ICW-1:0]  icnt_q, icnt_d;
	logic [SUM_W-1:0] isum_q, isum_d;
	logic [CW-1:0]   count_q, count_d;
	logic [SW-1:0]   wp_q, wp_d, sync_q, sync_d;
	logic            wrap_q, wrap_d, full_q, full_d;
	logic [SW-1:0]   s_q, s_d;
	logic [DW-1:0]   i_q, i_d;
	logic            rd_ok_q, rd_ok_d;
	logic            cp_v_s1;
	logic [DW-1:0]   cp_i_s1;
	logic            res_v_q, res_load;
	dvrs_out_t       res_q, res_d;

	// memory ports
	logic             inc_we;
	logic [DW-1:0]    inc_waddr, inc_raddr;
	logic [31:0]      inc_rdata;
	logic             st_we;
	logic [AW-1:0]    st_waddr, st_raddr;
	logic [31:0]      st_rdata;
	logic             sum_we;
	logic [SW-1:0]    sum_raddr;
	logic [SUM_W-1:0] sum_rdata;

	// helpers
	logic [CW-1:0]    cap_eff;
	logic             accept;
	logic [31:0]      abs_val;
	logic [ICW-1:0]   icnt_inc;
	logic [SUM_W-1:0] isum_inc;
	logic             len_bad;
	logic             last_slot, last_el;
	logic signed [32:0] diff;
	logic [32:0]      adiff;
	logic [SW:0]      wp_inc;
	logic [SW-1:0]    wp_new, sync_new;
	logic             wrap_new, full_new;
	logic [CW-1:0]    count_new;

	dvrs_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_inc_ram (
		.clk(clk), .we(inc_we), .waddr(inc_waddr), .wdata(item.element_value),
		.raddr(inc_raddr), .rdata(inc_rdata)
	);

	dvrs_ram #(.WIDTH(32), .DEPTH(SLOTS * MAX_DIM)) u_store_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(inc_rdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	dvrs_ram #(.WIDTH(SUM_W), .DEPTH(SLOTS)) u_sum_ram (
		.clk(clk), .we(sum_we), .waddr(wp_q), .wdata(isum_q),
		.raddr(sum_raddr), .rdata(sum_rdata)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= 7'd64;
			vlen_q <= 7'd64;
			tol_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAPACITY: cap_q  <= cfg_data[6:0];
				REG_VLEN:     vlen_q <= cfg_data[6:0];
				REG_TOL:      tol_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// effective capacity: zero acts as one, clipped to the slot count
	always_comb begin
		if (cap_q == 7'd0) begin
			cap_eff = CW'(1);
		end else if (32'(cap_q) > SLOTS) begin
			cap_eff = CW'(SLOTS);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end

	assign item_ready   = (state_q == ST_IDLE) && (!res_v_q || result_ready);
	assign accept       = item_valid && item_ready;
	assign result_valid = res_v_q;
	assign result       = res_q;

	// element intake arithmetic
	assign abs_val  = item.element_value[31] ? 32'(-item.element_value)
	                                         : 32'(item.element_value);
	assign icnt_inc = (32'(icnt_q) <= MAX_DIM) ? icnt_q + ICW'(1) : icnt_q;
	assign isum_inc = isum_q + SUM_W'(abs_val);
	assign len_bad  = (vlen_q == 7'd0) || (32'(vlen_q) > MAX_DIM) ||
	                  (32'(icnt_inc) != 32'(vlen_q));
	assign inc_we    = accept && (item.operation == OP_INSERT) && (32'(icnt_q) < MAX_DIM);
	assign inc_waddr = DW'(icnt_q);

	// scan / compare
	assign last_slot = (32'(s_q) + 1 >= 32'(count_q));
	assign last_el   = (32'(i_q) + 1 >= 32'(vlen_q));
	assign diff      = 33'(signed'(inc_rdata)) - 33'(signed'(st_rdata));
	assign adiff     = diff[32] ? 33'(-diff) : 33'(diff);

	// pointer update for a stored vector
	always_comb begin
		wp_inc = (SW + 1)'(wp_q) + (SW + 1)'(1);
		if (32'(wp_inc) >= 32'(cap_eff)) begin
			wp_new   = '0;
			wrap_new = 1'b1;
		end else begin
			wp_new   = SW'(wp_inc);
			wrap_new = wrap_q;
		end
		full_new  = full_q || (wrap_new && (wp_new == sync_q));
		sync_new  = full_new ? wp_new : sync_q;
		count_new = (count_q < cap_eff) ? count_q + CW'(1) : count_q;
	end

	// memory addressing
	assign inc_raddr = i_q;
	assign sum_raddr = s_q;
	assign st_raddr  = (state_q == ST_IDLE)
		? AW'(32'(item.read_slot) * MAX_DIM + 32'(item.read_element))
		: AW'(32'(s_q) * MAX_DIM + 32'(i_q));
	assign st_we     = cp_v_s1;
	assign st_waddr  = AW'(32'(wp_q) * MAX_DIM + 32'(cp_i_s1));
	assign sum_we    = (state_q == ST_COPY_END);

	// sequencer
	always_comb begin
		state_d  = state_q;
		icnt_d   = icnt_q;
		isum_d   = isum_q;
		count_d  = count_q;
		wp_d     = wp_q;
		sync_d   = sync_q;
		wrap_d   = wrap_q;
		full_d   = full_q;
		s_d      = s_q;
		i_d      = i_q;
		rd_ok_d  = rd_ok_q;
		res_load = 1'b0;
		res_d.status         = STAT_STORED;
		res_d.slot           = '0;
		res_d.count          = 7'(count_q);
		res_d.write_position = 6'(wp_q);
		res_d.sync_start     = 6'(sync_q);
		res_d.wrapped        = wrap_q;
		res_d.full_res       = full_q;
		res_d.read_value     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.operation)
						OP_INSERT: begin
							icnt_d = icnt_inc;
							isum_d = isum_inc;
							if (item.last) begin
								icnt_d = '0;
								s_d    = '0;
								i_d    = '0;
								if (len_bad) begin
									isum_d       = '0;
									res_load     = 1'b1;
									res_d.status = STAT_WRONG_LEN;
								end else if (count_q == '0) begin
									state_d = ST_COPY;
								end else begin
									state_d = ST_SUM_RD;
								end
							end
						end
						OP_SYNC: begin
							sync_d   = wp_q;
							wrap_d   = 1'b0;
							full_d   = 1'b0;
							res_load = 1'b1;
							res_d.status     = STAT_SYNC_DONE;
							res_d.sync_start = 6'(wp_q);
							res_d.wrapped    = 1'b0;
							res_d.full_res   = 1'b0;
						end
						OP_READ: begin
							rd_ok_d = (32'(item.read_slot) < 32'(count_q)) &&
							          (32'(item.read_slot) < SLOTS) &&
							          (32'(item.read_element) < 32'(vlen_q)) &&
							          (32'(item.read_element) < MAX_DIM);
							state_d = ST_RD_RES;
						end
						default: ;
					endcase
				end
			end
			ST_RD_RES: begin
				res_load         = 1'b1;
				res_d.status     = STAT_READ;
				res_d.read_value = rd_ok_q ? signed'(st_rdata) : '0;
				state_d          = ST_IDLE;
			end
			ST_SUM_RD: begin
				state_d = ST_SUM_CHK;
			end
			ST_SUM_CHK: begin
				if (sum_rdata == isum_q) begin
					i_d     = '0;
					state_d = ST_EL_RD;
				end else if (last_slot) begin
					i_d     = '0;
					state_d = ST_COPY;
				end else begin
					s_d     = s_q + SW'(1);
					state_d = ST_SUM_RD;
				end
			end
			ST_EL_RD: begin
				state_d = ST_EL_CHK;
			end
			ST_EL_CHK: begin
				if (adiff > {2'b00, tol_q}) begin
					i_d = '0;
					if (last_slot) begin
						state_d = ST_COPY;
					end else begin
						s_d     = s_q + SW'(1);
						state_d = ST_SUM_RD;
					end
				end else if (last_el) begin
					isum_d       = '0;
					res_load     = 1'b1;
					res_d.status = STAT_DUPLICATE;
					state_d      = ST_IDLE;
				end else begin
					i_d     = i_q + DW'(1);
					state_d = ST_EL_RD;
				end
			end
			ST_COPY: begin
				if (last_el) begin
					state_d = ST_COPY_END;
				end else begin
					i_d = i_q + DW'(1);
				end
			end
			ST_COPY_END: begin
				isum_d   = '0;
				count_d  = count_new;
				wp_d     = wp_new;
				sync_d   = sync_new;
				wrap_d   = wrap_new;
				full_d   = full_new;
				res_load = 1'b1;
				res_d.status         = STAT_STORED;
				res_d.slot           = 6'(wp_q);
				res_d.count          = 7'(count_new);
				res_d.write_position = 6'(wp_new);
				res_d.sync_start     = 6'(sync_new);
				res_d.wrapped        = wrap_new;
				res_d.full_res       = full_new;
				state_d              = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			icnt_q  <= '0;
			isum_q  <= '0;
			count_q <= '0;
			wp_q    <= '0;
			sync_q  <= '0;
			wrap_q  <= 1'b0;
			full_q  <= 1'b0;
			s_q     <= '0;
			i_q     <= '0;
			rd_ok_q <= 1'b0;
			cp_v_s1 <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			icnt_q  <= icnt_d;
			isum_q  <= isum_d;
			count_q <= count_d;
			wp_q    <= wp_d;
			sync_q  <= sync_d;
			wrap_q  <= wrap_d;
			full_q  <= full_d;
			s_q     <= s_d;
			i_q     <= i_d;
			rd_ok_q <= rd_ok_d;
			cp_v_s1 <= (state_q == ST_COPY);
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (result_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cp_i_s1 <= i_q;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= SLOTS) else $error("stored count above slot count");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < SLOTS) else $error("write pointer out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_v_q || result_ready))
		else $error("result register overwritten while held");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !item_ready) else $error("ready while busy");

endmodule
`default_nettype wire

// ----- rtl/dvrs_ram.sv -----
`default_nettype none
module dvrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
